// ----- hdl/bmr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, register indexes, format codes and the sample decoder of the
// band mean block.
// ----------------------------------------------------------------------------
package bmr_pkg;

	localparam int SAMPLE_W   = 33;
	localparam int SUM_W      = 41;
	localparam int CNT_W      = 8;
	localparam int FMT_W      = 3;
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [REG_IDX_W-1:0] REG_BAND_COUNT    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd1;

	localparam logic [CNT_W-1:0] BAND_COUNT_RST    = 8'd3;
	localparam logic [FMT_W-1:0] SAMPLE_FORMAT_RST = 3'd1;

	localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_U8  = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S16 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd4;
	localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} pixel_t;

	function automatic logic signed [SUM_W-1:0] decode_sample(
		input logic [SAMPLE_W-1:0] raw,
		input logic [FMT_W-1:0]    fmt
	);
		logic signed [SUM_W-1:0] v;
		unique case (fmt)
			FMT_S8:  v = SUM_W'(signed'(raw[7:0]));
			FMT_U8:  v = {{(SUM_W-8){1'b0}}, raw[7:0]};
			FMT_S16: v = SUM_W'(signed'(raw[15:0]));
			FMT_U16: v = {{(SUM_W-16){1'b0}}, raw[15:0]};
			FMT_S32: v = SUM_W'(signed'(raw[31:0]));
			default: v = {{(SUM_W-32){1'b0}}, raw[31:0]};
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bmr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_front
// Decodes each sample, accumulates the bands of a pixel and hands the
// finished sum with its band count to the pixel queue.
// ----------------------------------------------------------------------------
module bmr_front
	import bmr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [SAMPLE_W-1:0] sample,
	output logic                     full,
	input  wire logic                clear,
	input  wire logic [CNT_W-1:0]    count,
	input  wire logic [FMT_W-1:0]    fmt,
	output logic                     q_push,
	output pixel_t                   q_data,
	input  wire logic                q_full
);

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        idx_q;
	logic signed [SUM_W-1:0] sum_next;
	logic                    last;
	logic                    accept;

	assign sum_next = sum_q + decode_sample(sample, fmt);
	assign last     = ({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, count};
	assign full     = last && q_full;
	assign accept   = push && !full;
	assign q_push   = accept && last;
	assign q_data   = '{sum: sum_next, count: count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q <= '0;
				idx_q <= '0;
			end else begin
				sum_q <= sum_next;
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bmr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_fifo
// Short queue of finished pixel sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module bmr_fifo
	import bmr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire pixel_t wdata,
	output logic        full,
	input  wire logic   pop,
	output pixel_t      rdata,
	output logic        empty
);

	pixel_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W:0]     cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign full    = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bmr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_back
// Rounds and divides each pixel sum by its band count with a restoring
// divider, one quotient bit per cycle, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module bmr_back
	import bmr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pixel_t              q_data,
	input  wire logic                q_empty,
	output logic                     q_pop,
	output logic                     empty,
	input  wire logic                pop,
	output logic signed [SAMPLE_W-1:0] mean
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t           state_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      div_q;
	logic                  neg_q;
	logic [STEP_W-1:0]     step_q;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   mean_q;

	logic [SUM_W-1:0]      mag;
	logic [CNT_W:0]        rem_shift;
	logic                  fits;
	logic [SUM_W-1:0]      signed_res;
	logic                  load_out;

	assign mag = (q_data.sum[SUM_W-1] ? (~q_data.sum + SUM_W'(1)) : q_data.sum)
		+ {{(SUM_W-CNT_W+1){1'b0}}, q_data.count[CNT_W-1:1]};
	assign rem_shift  = {rem_q, quo_q[SUM_W-1]};
	assign fits       = rem_shift >= {1'b0, div_q};
	assign signed_res = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign load_out   = (state_q == B_DONE) && (!out_valid_q || pop);
	assign empty      = !out_valid_q;
	assign mean       = mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= (q_data.count == CNT_W'(1)) ? B_DONE : B_DIV;
					end
				end
				B_DIV: begin
					if (step_q == STEP_W'(SUM_W-1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q  <= mag;
			rem_q  <= '0;
			div_q  <= q_data.count;
			neg_q  <= q_data.sum[SUM_W-1];
			step_q <= '0;
		end else if (state_q == B_DIV) begin
			quo_q  <= {quo_q[SUM_W-2:0], fits};
			rem_q  <= fits ? CNT_W'(rem_shift - {1'b0, div_q}) : rem_shift[CNT_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
		if (load_out) begin
			mean_q <= signed_res[SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/band_mean_rounded.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// band_mean_rounded
// Per-pixel band average, rounded half away from zero, in the configured
// integer sample format.
//
//   channel   handshake          payload
//   -------   ----------------   -------------------------------
//   input     push / full        sample [32:0]
//   result    empty / pop        mean [32:0]
//   config    wr_en              wr_index [1:0], wr_data [7:0]
//
// The accumulator takes one sample per cycle while full is low. Between load
// and hand-off the divider runs 41 restoring steps for a pixel of two or
// more bands and none for one band; a two-entry queue holds finished sums.
// full rises only on a pixel's last band while that queue is full. Reset
// (arst_n low) restores band_count 3, sample_format u8 and drops all pixels
// in flight. A write to either register abandons the pixel in progress.
// ----------------------------------------------------------------------------
module band_mean_rounded
	import bmr_pkg::*;
#(
	parameter int MAX_BANDS = 255
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                        empty,
	input  wire logic                   pop,
	output logic signed [SAMPLE_W-1:0]  mean,
	input  wire logic                   wr_en,
	input  wire logic [REG_IDX_W-1:0]   wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data
);

	logic [CNT_W-1:0] band_count_q;
	logic [FMT_W-1:0] sample_format_q;
	logic [CNT_W-1:0] count_eff;
	logic             cfg_hit;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	pixel_t           q_wdata;
	pixel_t           q_rdata;

	assign cfg_hit = wr_en
		&& (wr_index == REG_BAND_COUNT || wr_index == REG_SAMPLE_FORMAT);

	always_comb begin
		count_eff = band_count_q;
		if (band_count_q == '0) begin
			count_eff = CNT_W'(1);
		end else if (32'(band_count_q) > MAX_BANDS) begin
			count_eff = CNT_W'(MAX_BANDS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q    <= BAND_COUNT_RST;
			sample_format_q <= SAMPLE_FORMAT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BAND_COUNT:    band_count_q    <= wr_data[CNT_W-1:0];
				REG_SAMPLE_FORMAT: sample_format_q <= wr_data[FMT_W-1:0];
				default: ;
			endcase
		end
	end

	bmr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (sample),
		.full   (full),
		.clear  (cfg_hit),
		.count  (count_eff),
		.fmt    (sample_format_q),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	bmr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	bmr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.mean    (mean)
	);

endmodule
`default_nettype wire

// ----- hdl/bmr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_checker
// Port-level checks of the band mean block: result hold under stall and
// range of the result for the active byte formats.
// ----------------------------------------------------------------------------
module bmr_checker
	import bmr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic [SAMPLE_W-1:0]   mean,
	input wire logic                  wr_en,
	input wire logic [REG_IDX_W-1:0]  wr_index,
	input wire logic [CFG_DATA_W-1:0] wr_data
);

	logic [FMT_W-1:0] fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= SAMPLE_FORMAT_RST;
		end else if (wr_en && wr_index == REG_SAMPLE_FORMAT) begin
			fmt_q <= wr_data[FMT_W-1:0];
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result transaction dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(mean))
		else $error("result payload changed while stalled");

	a_u8_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && fmt_q == FMT_U8) |-> (mean[SAMPLE_W-1:8] == '0))
		else $error("u8 mean out of range");

	a_s8_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && fmt_q == FMT_S8)
		|-> (mean[SAMPLE_W-1:7] == '0 || mean[SAMPLE_W-1:7] == '1))
		else $error("s8 mean not sign-extended");

endmodule

bind band_mean_rounded bmr_checker u_bmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.mean     (mean),
	.wr_en    (wr_en),
	.wr_index (wr_index),
	.wr_data  (wr_data)
);
`default_nettype wire
